### rtl/mlp_pkg.sv
// Shared types and constants for the MLP forward-pass block.
// No dependencies; imported by the sigmoid ROM and the top level.
package mlp_pkg;

  // Default sizes of the network storage.
  localparam int DEF_MAX_LAYERS      = 4;
  localparam int DEF_MAX_NEURONS     = 16;
  localparam int DEF_SIGMOID_ENTRIES = 1024;

  // Size registers exist for four layers only.
  localparam int SIZE_REGS  = 4;
  localparam int RESULT_CAP = 16;

  // Payload and configuration widths.
  localparam int VAL_W  = 16;
  localparam int SEL_W  = 4;
  localparam int LSEL_W = 2;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 5;
  localparam int LCNT_W = 3;

  // Actions carried by an input word.
  typedef enum logic [1:0] {
    ACT_LOAD_WEIGHT = 2'd0,
    ACT_LOAD_BIAS   = 2'd1,
    ACT_LOAD_INPUT  = 2'd2,
    ACT_RUN         = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_LAYER_COUNT = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SIZE_L0     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SIZE_L1     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SIZE_L2     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SIZE_L3     = 3'd4;

endpackage

### rtl/mlp_sigmoid_forward_pass.sv
// MLP forward pass with logistic activation; weights, biases and activations in RAMs.
// Weight and bias loads write their RAM straight from the input word; an input load
// goes through the sigmoid ROM (S_LD_ROM) before the activation write (S_LD_WR). A run
// has the single MAC walk the weight RAM one word a cycle. One item at a time.
// Reset (synchronous, rst_n low) restores default registers and zeroes activations
// through valid bits; weight and bias RAM contents persist and need no clearing.
module mlp_sigmoid_forward_pass #(
  parameter int MAX_LAYERS      = mlp_pkg::DEF_MAX_LAYERS,
  parameter int MAX_NEURONS     = mlp_pkg::DEF_MAX_NEURONS,
  parameter int SIGMOID_ENTRIES = mlp_pkg::DEF_SIGMOID_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mlp_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [mlp_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_action,
  input  logic [mlp_pkg::LSEL_W-1:0]         in_layer_sel,
  input  logic [mlp_pkg::SEL_W-1:0]          in_neuron_sel,
  input  logic [mlp_pkg::SEL_W-1:0]          in_target_sel,
  input  logic signed [mlp_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mlp_pkg::SEL_W-1:0]          out_index,
  output logic [mlp_pkg::VAL_W-1:0]          out_value,
  output logic                               out_last
);
  import mlp_pkg::*;

  localparam int NW       = $clog2(MAX_NEURONS);
  localparam int W_DEPTH  = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
  localparam int N_DEPTH  = MAX_LAYERS * MAX_NEURONS;
  localparam int WAW      = $clog2(W_DEPTH);
  localparam int NAW      = $clog2(N_DEPTH);
  localparam int IW       = $clog2(SIGMOID_ENTRIES);
  localparam int TOP_L    = (MAX_LAYERS < SIZE_REGS) ? MAX_LAYERS : SIZE_REGS;
  localparam int ACC_W    = 2 * VAL_W + 1 + NW + 2;
  localparam int PROD_W   = 2 * VAL_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_ROM, S_LD_WR, S_BIAS, S_MAC, S_DRAIN, S_SIG, S_WR, S_OUT_RD, S_OUT_LD
  } state_t;

  // Configuration registers.
  logic [LCNT_W-1:0] layer_count_r;
  logic [CFG_DW-1:0] size_r [SIZE_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= LCNT_W'(2);
      for (int k = 0; k < SIZE_REGS; k++) begin
        size_r[k] <= CFG_DW'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYER_COUNT: layer_count_r <= cfg_wdata[LCNT_W-1:0];
        CFG_SIZE_L0:     size_r[0] <= cfg_wdata;
        CFG_SIZE_L1:     size_r[1] <= cfg_wdata;
        CFG_SIZE_L2:     size_r[2] <= cfg_wdata;
        CFG_SIZE_L3:     size_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Layer size with out-of-range values clamped.
  function automatic logic [NW:0] size_of(input logic [CFG_DW-1:0] raw);
    logic [NW:0] res;
    if (raw == '0) begin
      res = (NW+1)'(1);
    end else if (int'(raw) > MAX_NEURONS) begin
      res = (NW+1)'(MAX_NEURONS);
    end else begin
      res = (NW+1)'(raw);
    end
    return res;
  endfunction

  logic [LCNT_W-1:0] n_layers;
  always_comb begin
    if (layer_count_r < LCNT_W'(2)) begin
      n_layers = LCNT_W'(2);
    end else if (int'(layer_count_r) > TOP_L) begin
      n_layers = LCNT_W'(TOP_L);
    end else begin
      n_layers = layer_count_r;
    end
  end

  // Sequencer registers.
  state_t            state_r;
  logic [LCNT_W-1:0] l_r;
  logic [NW-1:0]     i_r;
  logic [NW-1:0]     j_r;
  logic [SEL_W-1:0]  k_r;
  logic [SEL_W-1:0]  nsel_r;
  logic [VAL_W-1:0]  value_r;
  logic              rd_v_r;
  logic              prod_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic              out_valid_r;
  logic [SEL_W-1:0]  out_index_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_last_r;

  logic [NW:0] cur_size;
  logic [NW:0] prev_size;
  logic [NW:0] last_size;
  logic [SEL_W:0] out_count;
  assign cur_size  = size_of(size_r[l_r[1:0]]);
  assign prev_size = size_of(size_r[2'(l_r - LCNT_W'(1))]);
  assign last_size = size_of(size_r[2'(n_layers - LCNT_W'(1))]);
  assign out_count = (int'(last_size) > RESULT_CAP) ? (SEL_W+1)'(RESULT_CAP)
                                                    : (SEL_W+1)'(last_size);

  logic in_acc;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Weight RAM: written by load words, read by the MAC loop.
  logic             w_we;
  logic [WAW-1:0]   w_waddr;
  logic [WAW-1:0]   w_raddr;
  logic [VAL_W-1:0] w_q;
  logic             mac_issue;
  assign w_we = in_acc && (in_action == ACT_LOAD_WEIGHT) && (int'(in_layer_sel) < MAX_LAYERS - 1)
                && (int'(in_neuron_sel) < MAX_NEURONS) && (int'(in_target_sel) < MAX_NEURONS);
  assign w_waddr = WAW'((int'(in_layer_sel) * MAX_NEURONS + int'(in_neuron_sel)) * MAX_NEURONS
                        + int'(in_target_sel));
  assign w_raddr = WAW'((int'(l_r - LCNT_W'(1)) * MAX_NEURONS + int'(i_r)) * MAX_NEURONS
                        + int'(j_r));
  assign mac_issue = (state_r == S_MAC);

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_value),
    .re(mac_issue), .raddr(w_raddr), .rdata(w_q)
  );

  // Bias RAM.
  logic             b_we;
  logic [VAL_W-1:0] b_q;
  assign b_we = in_acc && (in_action == ACT_LOAD_BIAS) && (int'(in_layer_sel) < MAX_LAYERS)
                && (int'(in_neuron_sel) < MAX_NEURONS);

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(N_DEPTH)) u_bias_ram (
    .clk(clk), .we(b_we),
    .waddr(NAW'(int'(in_layer_sel) * MAX_NEURONS + int'(in_neuron_sel))),
    .wdata(in_value), .re(state_r == S_BIAS),
    .raddr(NAW'(int'(l_r) * MAX_NEURONS + int'(j_r))), .rdata(b_q)
  );

  // Activation RAM with per-entry valid bits so that reset reads as zero.
  logic             a_we;
  logic [NAW-1:0]   a_waddr;
  logic             a_re;
  logic [NAW-1:0]   a_raddr;
  logic [VAL_W-1:0] a_q;
  logic [VAL_W-1:0] rom_q;
  logic [N_DEPTH-1:0] a_vld_r;
  logic             a_vq_r;
  logic [VAL_W-1:0] act_word;

  assign a_we    = (state_r == S_LD_WR) || (state_r == S_WR);
  assign a_waddr = (state_r == S_LD_WR) ? NAW'(nsel_r)
                                        : NAW'(int'(l_r) * MAX_NEURONS + int'(j_r));
  assign a_re    = mac_issue || (state_r == S_OUT_RD);
  assign a_raddr = mac_issue ? NAW'(int'(l_r - LCNT_W'(1)) * MAX_NEURONS + int'(i_r))
                             : NAW'(int'(n_layers - LCNT_W'(1)) * MAX_NEURONS + int'(k_r));

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(N_DEPTH)) u_act_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(rom_q),
    .re(a_re), .raddr(a_raddr), .rdata(a_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
    end else if (a_we) begin
      a_vld_r[a_waddr] <= 1'b1;
    end
    if (a_re) begin
      a_vq_r <= a_vld_r[a_raddr];
    end
  end

  assign act_word = a_vq_r ? a_q : '0;

  // Saturated Q4.12 neuron sum; floor comes from the arithmetic shift.
  logic signed [ACC_W-17:0] acc_sh;
  logic [VAL_W-1:0] sat_sum;
  always_comb begin
    acc_sh = acc_r[ACC_W-1:16];
    if (acc_sh > (ACC_W-16)'(32767)) begin
      sat_sum = 16'h7FFF;
    end else if (acc_sh < -(ACC_W-16)'(32768)) begin
      sat_sum = 16'h8000;
    end else begin
      sat_sum = acc_sh[VAL_W-1:0];
    end
  end

  // Sigmoid lookup: offset binary of the Q4.12 word scaled to the table.
  logic [VAL_W-1:0] rom_x;
  logic [IW-1:0]    rom_addr;
  assign rom_x    = (state_r == S_LD_ROM) ? value_r : sat_sum;
  assign rom_addr = IW'((32'(rom_x ^ 16'h8000) * 32'(SIGMOID_ENTRIES)) >> 16);

  mlp_sig_rom #(.ENTRIES(SIGMOID_ENTRIES)) u_sig_rom (
    .clk(clk), .addr(rom_addr), .rdata(rom_q)
  );

  // Sequencer with the MAC pipeline and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      l_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      rd_v_r   <= mac_issue;
      prod_v_r <= rd_v_r;
      if (rd_v_r) begin
        prod_r <= PROD_W'(signed'({1'b0, act_word}) * PROD_W'(signed'(w_q)));
      end
      if (prod_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      // In the load state a taken word is replaced by the next one below.
      if (out_valid_r && out_ready && (state_r != S_OUT_LD)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            nsel_r  <= in_neuron_sel;
            value_r <= in_value;
            if (in_action == ACT_LOAD_INPUT) begin
              if (int'(in_neuron_sel) < MAX_NEURONS) begin
                state_r <= S_LD_ROM;
              end
            end else if (in_action == ACT_RUN) begin
              l_r     <= LCNT_W'(1);
              j_r     <= '0;
              state_r <= S_BIAS;
            end
          end
        end
        S_LD_ROM: state_r <= S_LD_WR;
        S_LD_WR:  state_r <= S_IDLE;
        S_BIAS: begin
          i_r     <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          // Bias data arrives in the first MAC cycle and seeds the sum.
          if (i_r == '0) begin
            acc_r <= ACC_W'(signed'(b_q)) <<< 16;
          end
          if ((NW+1)'(i_r) == prev_size - (NW+1)'(1)) begin
            state_r <= S_DRAIN;
          end else begin
            i_r <= i_r + NW'(1);
          end
        end
        S_DRAIN: begin
          if (!rd_v_r && !prod_v_r) begin
            state_r <= S_SIG;
          end
        end
        S_SIG: state_r <= S_WR;
        S_WR: begin
          if ((NW+1)'(j_r) != cur_size - (NW+1)'(1)) begin
            j_r     <= j_r + NW'(1);
            state_r <= S_BIAS;
          end else if (l_r != n_layers - LCNT_W'(1)) begin
            l_r     <= l_r + LCNT_W'(1);
            j_r     <= '0;
            state_r <= S_BIAS;
          end else begin
            k_r     <= '0;
            state_r <= S_OUT_RD;
          end
        end
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_index_r <= k_r;
            out_value_r <= act_word;
            out_last_r  <= ((SEL_W+1)'(k_r) == out_count - (SEL_W+1)'(1));
            if ((SEL_W+1)'(k_r) == out_count - (SEL_W+1)'(1)) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + SEL_W'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // The MAC pipeline is empty whenever a new word can be taken.
  a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!rd_v_r && !prod_v_r))
    else $error("MAC pipeline busy while idle");

  // A product is only formed from a read issued the cycle before.
  a_prod_src: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r |-> $past(rd_v_r))
    else $error("product without weight read");

  // The sigmoid is taken only after all products have been summed.
  a_sig_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIG) |-> (!rd_v_r && !prod_v_r))
    else $error("sigmoid taken before sum complete");

  // Activation writes come only from the input load or the neuron update.
  a_act_write: assert property (@(posedge clk) disable iff (!rst_n)
    a_we |-> $past(state_r == S_LD_ROM || state_r == S_SIG))
    else $error("activation write without ROM lookup");

endmodule

### rtl/mlp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mlp_sig_rom.sv
// Logistic function table over [-8, 8) with a registered read port.
// Contents are built at elaboration; depends on mlp_pkg for the value width.
module mlp_sig_rom #(
  parameter int ENTRIES = mlp_pkg::DEF_SIGMOID_ENTRIES
) (
  input  logic                       clk,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  output logic [mlp_pkg::VAL_W-1:0]  rdata
);
  import mlp_pkg::*;

  typedef logic [VAL_W-1:0] rom_t [ENTRIES];

  // Unsigned long division by shift and subtract, used only while the
  // table is built.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Each entry samples the left edge of its interval; e^t comes from a
  // truncated Taylor series in Q32.
  function automatic rom_t build_rom();
    rom_t              tbl;
    longint            xq;
    longint unsigned   t;
    longint unsigned   sum;
    longint unsigned   term;
    longint unsigned   d;
    longint unsigned   s;
    longint unsigned   v;
    bit                done;
    for (int i = 0; i < ENTRIES; i++) begin
      xq   = -64'sd32768 + longint'(udiv(longint'(i) * 65536, longint'(ENTRIES)));
      t    = (xq < 0) ? longint'(-xq) : longint'(xq);
      sum  = 64'd1 << 32;
      term = 64'd1 << 32;
      done = 1'b0;
      for (int n = 1; n <= 64; n++) begin
        if (!done) begin
          // Dividing by 4096 first and then by n gives the same floor.
          term = udiv((term * t) >> 12, longint'(n));
          if (term == 0) begin
            done = 1'b1;
          end else begin
            sum = sum + term;
          end
        end
      end
      d = (64'd1 << 32) + sum;
      s = udiv((64'd1 << 48) + (d >> 1), d);
      v = (xq < 0) ? s : (64'd65536 - s);
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      tbl[i] = v[VAL_W-1:0];
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    rdata_r <= ROM[addr];
  end

  assign rdata = rdata_r;

endmodule
